### hw/rtl/lbp_pkg.sv
`timescale 1ns / 1ps

package lbp_pkg;

   // fixed field widths
   localparam int FIELD_W            = 64;
   localparam int COUNT_W            = 7;
   localparam int MSG_W              = 32;
   localparam int BYTE_W             = 8;
   localparam int PEND_W             = 7;
   localparam int MAX_FIELD_BITS_DEF = 64;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((FIELD_W + COUNT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((BYTE_W + MSG_W + 7) / 8) * 8;

   // controller to datapath
   typedef struct packed {
      logic load;    // take the accepted beat into the bit buffer
      logic emit;    // move the low byte into the output register
      logic finish;  // close the item: update bit position, flush on end of message
   } lbp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic has_byte;  // a byte is ready to leave the buffer
      logic is_last;   // that byte is the last one of the item
      logic out_free;  // output register can take a byte this cycle
   } lbp_status_type;

endpackage

### hw/rtl/lsb_first_bit_packer_unit.sv
`timescale 1ns / 1ps

// lsb-first variable length bit packer
// input beats carry a value and its bit count (clamped to 64); the bits are
// appended least significant bit first behind the bits of earlier beats, and
// every completed byte leaves as one output beat. req_tlast marks the end of
// a message: a partial byte is sent padded with zeros and the bit count of
// the message restarts. each output beat carries the byte and the saturating
// bit count of the message up to and including its input beat; rsp_tlast
// marks the last byte caused by one input beat.
// an input beat occupies the unit until every byte it completes has left
// the bit buffer (at most nine for a 64-bit field with end of message), one
// byte per cycle through the single output register while the receiver
// takes them. bytes move from the bit buffer into the output register; when
// the receiver stalls, that register holds its byte and byte extraction
// waits. a new input beat may still be taken while the final byte of the
// previous one waits. reset clears the pending bits, the bit count and the
// output valid; no beat is held across reset.
module lsb_first_bit_packer_unit #(
   parameter int MAX_FIELD_BITS = lbp_pkg::MAX_FIELD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // field_value [63:0], field_bits [70:64], zero [71]
   input  logic [lbp_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // packed_byte [7:0], message_bits [39:8]
   output logic [lbp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast
);
   import lbp_pkg::*;

   lbp_cmd_type    cmd;
   lbp_status_type status;

   logic [BYTE_W-1:0] packed_byte;
   logic [MSG_W-1:0]  message_bits;

   // sequencing
   lbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // bit buffer and output register
   lbp_dpath #(
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .field_value    (req_tdata[FIELD_W-1:0]),
      .field_bits     (req_tdata[FIELD_W+COUNT_W-1:FIELD_W]),
      .end_of_message (req_tlast),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .packed_byte    (packed_byte),
      .last_of_run    (rsp_tlast),
      .message_bits   (message_bits)
   );

   assign rsp_tdata = RSP_DATA_W'({message_bits, packed_byte});

endmodule

### hw/rtl/lbp_ctrl.sv
`timescale 1ns / 1ps

module lbp_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  lbp_pkg::lbp_status_type     status,
   output lbp_pkg::lbp_cmd_type        cmd
);
   import lbp_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.has_byte) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.is_last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/lbp_dpath.sv
`timescale 1ns / 1ps

module lbp_dpath #(
   parameter int MAX_FIELD_BITS = lbp_pkg::MAX_FIELD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lbp_pkg::FIELD_W-1:0]   field_value,
   input  logic [lbp_pkg::COUNT_W-1:0]   field_bits,
   input  logic                          end_of_message,
   input  lbp_pkg::lbp_cmd_type          cmd,
   output lbp_pkg::lbp_status_type       status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lbp_pkg::BYTE_W-1:0]    packed_byte,
   output logic                          last_of_run,
   output logic [lbp_pkg::MSG_W-1:0]     message_bits
);
   import lbp_pkg::*;

   localparam int BUF_W = MAX_FIELD_BITS + PEND_W;
   localparam int TOT_W = $clog2(BUF_W + 1);

   localparam logic [COUNT_W-1:0] MAX_NB  = COUNT_W'(MAX_FIELD_BITS);
   localparam logic [TOT_W:0]     ONE_B   = (TOT_W + 1)'(BYTE_W);
   localparam logic [TOT_W:0]     TWO_B   = (TOT_W + 1)'(2 * BYTE_W);

   logic [BUF_W-1:0]  buf_ff,    buf_in;
   logic [TOT_W-1:0]  total_ff,  total_in;
   logic              eom_ff;
   logic [MSG_W-1:0]  msg_ff;
   logic [MSG_W-1:0]  bitpos_ff, bitpos_in;
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;
   logic [MSG_W-1:0]  rsp_msg_ff;

   logic [COUNT_W-1:0]        nb;
   logic [FIELD_W-1:0]        mask;
   logic [FIELD_W-1:0]        val_masked;
   logic [BUF_W-1:0]          val_placed;
   logic [BUF_W-1:0]          load_buf;
   logic [TOT_W-1:0]          load_total;
   logic [MSG_W:0]            msg_sum;
   logic [MSG_W-1:0]          msg_sat;
   logic [TOT_W:0]            total_x;

   // clamp the count and mask stray data bits
   always_comb begin
      nb   = (field_bits > MAX_NB) ? MAX_NB : field_bits;
      mask = (nb >= COUNT_W'(FIELD_W)) ? {FIELD_W{1'b1}} : ~({FIELD_W{1'b1}} << nb);
      val_masked = field_value & mask;
   end

   // append the new field above the pending bits
   always_comb begin
      val_placed = BUF_W'(val_masked[MAX_FIELD_BITS-1:0]) << total_ff[2:0];
      load_buf   = val_placed | BUF_W'(buf_ff[PEND_W-1:0]);
      load_total = TOT_W'(total_ff[2:0]) + TOT_W'(nb);
   end

   // saturating message length
   always_comb begin
      msg_sum = {1'b0, bitpos_ff} + (MSG_W + 1)'(nb);
      msg_sat = msg_sum[MSG_W] ? {MSG_W{1'b1}} : msg_sum[MSG_W-1:0];
   end

   // status toward the controller
   always_comb begin
      total_x         = {1'b0, total_ff};
      status.has_byte = (total_x >= ONE_B) || (eom_ff && (total_ff != '0));
      status.is_last  = (total_x < ONE_B) ||
                        ((total_x < TWO_B) && !(eom_ff && (total_x != ONE_B)));
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   // buffer, count and bit position updates
   always_comb begin
      buf_in    = buf_ff;
      total_in  = total_ff;
      bitpos_in = bitpos_ff;
      if (cmd.load) begin
         buf_in   = load_buf;
         total_in = load_total;
      end
      if (cmd.emit) begin
         buf_in   = buf_ff >> BYTE_W;
         total_in = (total_x >= ONE_B) ? (total_ff - TOT_W'(BYTE_W)) : '0;
      end
      if (cmd.finish) begin
         if (eom_ff) begin
            buf_in    = '0;
            total_in  = '0;
            bitpos_in = '0;
         end else begin
            bitpos_in = msg_ff;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         total_ff     <= '0;
         bitpos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff    <= buf_in;
         total_ff  <= total_in;
         bitpos_ff <= bitpos_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // per item payload and output register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         eom_ff <= end_of_message;
         msg_ff <= msg_sat;
      end
      if (cmd.emit) begin
         rsp_byte_ff <= buf_ff[BYTE_W-1:0];
         rsp_last_ff <= status.is_last;
         rsp_msg_ff  <= msg_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign packed_byte  = rsp_byte_ff;
   assign last_of_run  = rsp_last_ff;
   assign message_bits = rsp_msg_ff;

endmodule

### sim/lbp_stream_checker.sv
`timescale 1ns / 1ps

// watches both streams of the bit packer, predicts the packed bytes of every
// accepted field beat and compares each output beat with the oldest prediction
module lbp_stream_checker #(
   parameter int MAX_FIELD_BITS = lbp_pkg::MAX_FIELD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // field_value [63:0], field_bits [70:64], zero [71]
   input  logic [lbp_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // packed_byte [7:0], message_bits [39:8]
   input  logic [lbp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             rsp_tlast,
   output int                               fail_count,
   output int                               bytes_waiting,
   output int                               bytes_checked
);

   localparam int VAL_W = lbp_pkg::FIELD_W;
   localparam int CNT_W = lbp_pkg::COUNT_W;
   localparam int MSG_W = lbp_pkg::MSG_W;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             run_last;
      logic [MSG_W-1:0] msg_bits;
   } packed_beat_type;

   // predicted byte stream, oldest first
   packed_beat_type expected_bytes_q[$];

   // predictor state: unfinished byte, its fill level, message bit count
   logic [7:0]       acc_bits;
   int               acc_count;
   logic [MSG_W-1:0] run_bits;

   int mismatches = 0;
   int n_checked  = 0;

   // append the low bits of one field and queue every byte it completes
   task automatic pack_expected_bytes(input logic [VAL_W-1:0] value,
                                      input logic [CNT_W-1:0] count,
                                      input logic             eom);
      packed_beat_type made [9];
      int             n;
      int             take;
      logic [MSG_W:0] sum;
      logic [MSG_W-1:0] total;
      n    = 0;
      take = (int'(count) > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(count);
      sum  = {1'b0, run_bits} + (MSG_W + 1)'(take);
      // message length saturates instead of wrapping
      total = sum[MSG_W] ? {MSG_W{1'b1}} : sum[MSG_W-1:0];
      for (int i = 0; i < take; i++) begin
         acc_bits[acc_count] = value[i];
         acc_count++;
         if (acc_count == 8) begin
            made[n] = '{acc_bits, 1'b0, total};
            n++;
            acc_bits  = '0;
            acc_count = 0;
         end
      end
      // end of message flushes a partial byte, zero padded, and restarts the count
      if (eom) begin
         if (acc_count > 0) begin
            made[n] = '{acc_bits, 1'b0, total};
            n++;
         end
         acc_bits  = '0;
         acc_count = 0;
         run_bits  = '0;
      end else begin
         run_bits = total;
      end
      if (n > 0)
         made[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++)
         expected_bytes_q.push_back(made[i]);
   endtask

   // compare one output beat with the oldest predicted byte
   task automatic compare_packed_byte();
      packed_beat_type want;
      if (expected_bytes_q.size() == 0) begin
         $error("packed byte 0x%02h arrived with no byte expected", rsp_tdata[7:0]);
         mismatches++;
      end else begin
         want = expected_bytes_q.pop_front();
         n_checked++;
         if (rsp_tdata[7:0] !== want.out_byte) begin
            $error("packed_byte: expected 0x%02h, got 0x%02h", want.out_byte, rsp_tdata[7:0]);
            mismatches++;
         end
         if (rsp_tlast !== want.run_last) begin
            $error("last_of_run: expected %0b, got %0b", want.run_last, rsp_tlast);
            mismatches++;
         end
         if (rsp_tdata[8 +: MSG_W] !== want.msg_bits) begin
            $error("message_bits: expected %0d, got %0d", want.msg_bits, rsp_tdata[8 +: MSG_W]);
            mismatches++;
         end
      end
   endtask

   // sample both channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         expected_bytes_q.delete();
         acc_bits  = '0;
         acc_count = 0;
         run_bits  = '0;
      end else begin
         if (req_tvalid && req_tready)
            pack_expected_bytes(req_tdata[VAL_W-1:0], req_tdata[VAL_W +: CNT_W], req_tlast);
         if (rsp_tvalid && rsp_tready)
            compare_packed_byte();
      end
      fail_count    <= mismatches;
      bytes_waiting <= expected_bytes_q.size();
      bytes_checked <= n_checked;
   end

endmodule

### sim/tb_lsb_first_bit_packer_unit.sv
`timescale 1ns / 1ps

module tb_lsb_first_bit_packer_unit;

   localparam int MAX_BITS    = lbp_pkg::MAX_FIELD_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BEATS = 67;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   // field_value [63:0], field_bits [70:64], zero [71]
   logic [lbp_pkg::REQ_DATA_W-1:0]   req_tdata;
   logic                             req_tlast;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // packed_byte [7:0], message_bits [39:8]
   logic [lbp_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             rsp_tlast;

   int fail_count;
   int bytes_waiting;
   int bytes_checked;
   int cycle_count   = 0;
   int fields_sent   = 0;
   int messages_sent = 0;
   int gap_pct       = 0;
   int stall_pct     = 0;
   bit calm_tail     = 1'b0;

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   lsb_first_bit_packer_unit #(
      .MAX_FIELD_BITS (MAX_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   lbp_stream_checker #(
      .MAX_FIELD_BITS (MAX_BITS)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .bytes_waiting (bytes_waiting),
      .bytes_checked (bytes_checked)
   );

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stall bursts, none in the tail
   initial begin : ready_driver
      int hold;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
            hold = $urandom_range(1, 14);
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // present one field beat, with an optional idle burst ahead of it
   task automatic send_field(input logic [63:0] value, input logic [6:0] count,
                             input logic eom);
      int gap;
      if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, count, value};
      req_tlast  <= eom;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fields_sent++;
      if (eom)
         messages_sent++;
   endtask

   // mostly short fields, some long, zero and oversized counts now and then
   function automatic logic [6:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)       return 7'd0;
      else if (r < 60) return 7'($urandom_range(1, 12));
      else if (r < 80) return 7'($urandom_range(13, 40));
      else if (r < 90) return 7'($urandom_range(41, 63));
      else if (r < 95) return 7'(MAX_BITS);
      else             return 7'($urandom_range(65, 127));
   endfunction

   function automatic logic [63:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)       return 64'h0;
      else if (r < 10) return ALL_ONES;
      else             return {$urandom, $urandom};
   endfunction

   // stimulus
   initial begin : stimulus
      int fields;
      int in_phase;
      logic eom;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero and oversized counts, stray bits, flushes
      gap_pct   = 25;
      stall_pct = 25;
      send_field(64'h0, 7'd0, 1'b0);
      send_field(ALL_ONES, 7'd64, 1'b0);
      send_field(64'h0, 7'd64, 1'b0);
      send_field(64'h5, 7'd3, 1'b0);
      send_field(ALL_ONES, 7'd64, 1'b1);           // nine bytes with the flush
      send_field(ALL_ONES, 7'd0, 1'b1);            // flush with nothing pending
      send_field(ALL_ONES, 7'd1, 1'b0);            // stray bits above the count
      send_field(64'h0, 7'd0, 1'b1);               // zero count flushes one bit
      send_field(64'hDEAD_BEEF_0123_4567, 7'd127, 1'b0);
      send_field(64'hA5A5_5A5A_C3C3_3C3C, 7'd65, 1'b1);
      send_field(ALL_ONES, 7'd5, 1'b0);
      send_field(64'h0, 7'd3, 1'b0);
      send_field(64'h3, 7'd2, 1'b1);
      for (int i = 0; i < 8; i++)
         send_field(64'hFFFF_FFFF_FFFF_FFFD, 7'd1, 1'b0);
      send_field(64'h0, 7'd0, 1'b1);
      send_field(64'h8000_0000_0000_0000, 7'd64, 1'b1);
      send_field(64'h7F, 7'd7, 1'b1);

      // random messages in phases of different idle pressure, quiet tail last
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin gap_pct = 20; stall_pct = 20; end
            1: begin gap_pct = 0;  stall_pct = 0;  end
            2: begin gap_pct = 50; stall_pct = 45; end
            3: begin gap_pct = 8;  stall_pct = 60; end
            default: calm_tail = 1'b1;
         endcase
         in_phase = 0;
         while (in_phase < PHASE_BEATS) begin
            fields = $urandom_range(1, 10);
            for (int k = 0; k < fields; k++) begin
               // occasionally cut a message short
               eom = (k == fields - 1) || ($urandom_range(0, 29) == 0);
               send_field(pick_value(), pick_count(), eom);
               in_phase++;
            end
         end
      end
      req_tvalid <= 1'b0;

      // drain, then allow for the block's own latency
      @(posedge clock);
      while (bytes_waiting != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("sent %0d field beats in %0d messages, checked %0d packed bytes",
               fields_sent, messages_sent, bytes_checked);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sim.f
hw/rtl/lbp_pkg.sv
hw/rtl/lbp_ctrl.sv
hw/rtl/lbp_dpath.sv
hw/rtl/lsb_first_bit_packer_unit.sv
sim/lbp_stream_checker.sv
sim/tb_lsb_first_bit_packer_unit.sv
